[rtl/cau_pkg.sv]
// shared codes, types and default sizes for the complex arithmetic unit
package cau_pkg;

    // default operand format
    localparam int DATA_WIDTH_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    // field widths
    localparam int OP_W  = 3;
    localparam int ST_W  = 2;
    localparam int CLS_W = 3;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_MAG = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK  = 2'd0;
    localparam logic [ST_W-1:0] ST_DZ  = 2'd1;
    localparam logic [ST_W-1:0] ST_SAT = 2'd2;

    // request class decided at the front
    typedef enum logic [CLS_W-1:0] {
        CLS_NONE,
        CLS_ADD,
        CLS_SUB,
        CLS_MUL,
        CLS_DIV,
        CLS_MAG,
        CLS_DZ
    } cls_t;

endpackage

[rtl/cau_front.sv]
// front end: takes requests and classifies them for the back end
module cau_front #(
    parameter int DATA_WIDTH = 32,
    localparam int IN_W  = cau_pkg::OP_W + 4 * DATA_WIDTH,
    localparam int ENT_W = cau_pkg::CLS_W + 4 * DATA_WIDTH
) (
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // operation, a_re, a_im, b_re, b_im
    output logic             push_valid,
    input  logic             push_ready,
    output logic [ENT_W-1:0] push_data  // a_re, a_im, b_re, b_im, class
);
    import cau_pkg::*;

    localparam int W = DATA_WIDTH;

    logic [OP_W-1:0] op;
    logic [W-1:0]    ar, ai, br, bi;
    logic            b_zero;
    cls_t            cls;

    // field split
    always_comb begin
        op = s_tdata[OP_W-1:0];
        ar = s_tdata[OP_W +: W];
        ai = s_tdata[OP_W + W +: W];
        br = s_tdata[OP_W + 2*W +: W];
        bi = s_tdata[OP_W + 3*W +: W];
        b_zero = (br == '0) && (bi == '0);
    end

    // classify, divide by zero is settled here
    always_comb begin
        unique case (op)
            OP_ADD:  cls = CLS_ADD;
            OP_SUB:  cls = CLS_SUB;
            OP_MUL:  cls = CLS_MUL;
            OP_DIV:  cls = b_zero ? CLS_DZ : CLS_DIV;
            OP_MAG:  cls = CLS_MAG;
            default: cls = CLS_NONE;
        endcase
    end

    // hand off to the queue
    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;
    assign push_data  = {cls, bi, br, ai, ar};

endmodule

[rtl/cau_queue.sv]
// small request queue between front and back end
module cau_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             push, pop;

    // flags
    assign in_ready  = (cnt_reg != CW'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        cnt_next = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[rtl/cau_back.sv]
// back end: multiply, prepare, divide and square root pipeline, output register
module cau_back #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    localparam int ENT_W = cau_pkg::CLS_W + 4 * DATA_WIDTH,
    localparam int OUT_W = 2 * DATA_WIDTH + cau_pkg::ST_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [ENT_W-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] out_data   // result_re, result_im, status
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int NW = 2 * W;
    localparam int EW = NW + 2;
    localparam int XW = NW + F;
    localparam int CW = XW + W;
    localparam int RW = NW + 1;

    typedef struct packed {
        cls_t          cls;
        logic [W-1:0]  fx_re;
        logic [W-1:0]  fx_im;
        logic          fx_sat;
        logic [NW-1:0] den;
        logic [XW-1:0] rr_re;
        logic [XW-1:0] rr_im;
        logic [W-1:0]  q_re;
        logic [W-1:0]  q_im;
        logic          neg_re;
        logic          neg_im;
        logic          ovf_re;
        logic          ovf_im;
        logic [NW-1:0] srem;
        logic [W-1:0]  sroot;
    } stg_t;

    // saturate a wide signed value, returns {sat, value}
    function automatic logic [W:0] sat_fn(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] smax;
        logic signed [EW-1:0] smin;
        smax = $signed({{(EW-W+1){1'b0}}, {(W-1){1'b1}}});
        smin = $signed({{(EW-W+1){1'b1}}, {(W-1){1'b0}}});
        if (v > smax) begin
            sat_fn = {1'b1, smax[W-1:0]};
        end else if (v < smin) begin
            sat_fn = {1'b1, smin[W-1:0]};
        end else begin
            sat_fn = {1'b0, v[W-1:0]};
        end
    endfunction

    // drop fraction bits, truncating toward zero
    function automatic logic signed [EW-1:0] trunc_fn(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] rnd;
        logic signed [EW-1:0] t;
        rnd = $signed((EW'(1) << F) - EW'(1));
        t   = v[EW-1] ? v + rnd : v;
        trunc_fn = t >>> F;
    endfunction

    // sign a quotient magnitude and saturate, returns {sat, value}
    function automatic logic [W:0] div_fn(input logic [W-1:0] q, input logic neg,
                                          input logic ovf);
        logic [W-1:0] lim_n;
        logic [W-1:0] lim_p;
        lim_n = {1'b1, {(W-1){1'b0}}};
        lim_p = {1'b0, {(W-1){1'b1}}};
        if (neg) begin
            if (ovf || (q > lim_n)) div_fn = {1'b1, lim_n};
            else                    div_fn = {1'b0, W'(0) - q};
        end else begin
            if (ovf || (q > lim_p)) div_fn = {1'b1, lim_p};
            else                    div_fn = {1'b0, q};
        end
    endfunction

    logic en;
    logic out_vld_reg;
    logic [OUT_W-1:0] out_data_reg;

    assign en        = !out_vld_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    // multiply stage
    cls_t                 e_cls;
    logic signed [W-1:0]  e_ar, e_ai, e_br, e_bi, x0, x1;
    logic signed [NW-1:0] p0_next, p1_next, p2_next, p3_next, p4_next, p5_next;
    logic                 m_vld_reg;
    cls_t                 m_cls_reg;
    logic signed [W-1:0]  m_ar_reg, m_ai_reg, m_br_reg, m_bi_reg;
    logic signed [NW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;

    always_comb begin
        e_cls = cls_t'(in_data[ENT_W-1 -: CLS_W]);
        e_ar  = $signed(in_data[0 +: W]);
        e_ai  = $signed(in_data[W +: W]);
        e_br  = $signed(in_data[2*W +: W]);
        e_bi  = $signed(in_data[3*W +: W]);
        // magnitude reuses the first two products for the squares of a
        x0 = (e_cls == CLS_MAG) ? e_ar : e_br;
        x1 = (e_cls == CLS_MAG) ? e_ai : e_bi;
        p0_next = e_ar * x0;
        p1_next = e_ai * x1;
        p2_next = e_ar * e_bi;
        p3_next = e_br * e_ai;
        p4_next = e_br * e_br;
        p5_next = e_bi * e_bi;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (en) begin
            m_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_cls_reg <= e_cls;
            m_ar_reg  <= e_ar;
            m_ai_reg  <= e_ai;
            m_br_reg  <= e_br;
            m_bi_reg  <= e_bi;
            p0_reg    <= p0_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            p3_reg    <= p3_next;
            p4_reg    <= p4_next;
            p5_reg    <= p5_next;
        end
    end

    // prepare stage: finish add, subtract, multiply; set up divide and root
    logic signed [EW-1:0] x_ar, x_ai, x_br, x_bi;
    logic signed [EW-1:0] v_re, v_im, n_re, n_im, den_s;
    logic [NW-1:0]        mag_re, mag_im, a_den;
    logic [W-1:0]         f_re, f_im;
    logic                 f_sr, f_si;
    stg_t                 a_stg;

    always_comb begin
        x_ar  = EW'(m_ar_reg);
        x_ai  = EW'(m_ai_reg);
        x_br  = EW'(m_br_reg);
        x_bi  = EW'(m_bi_reg);
        n_re  = EW'(p0_reg) + EW'(p1_reg);
        n_im  = EW'(p3_reg) - EW'(p2_reg);
        den_s = EW'(p4_reg) + EW'(p5_reg);
        unique case (m_cls_reg)
            CLS_ADD: begin
                v_re = x_ar + x_br;
                v_im = x_ai + x_bi;
            end
            CLS_SUB: begin
                v_re = x_ar - x_br;
                v_im = x_ai - x_bi;
            end
            CLS_MUL: begin
                v_re = trunc_fn(EW'(p0_reg) - EW'(p1_reg));
                v_im = trunc_fn(EW'(p2_reg) + EW'(p3_reg));
            end
            default: begin
                v_re = '0;
                v_im = '0;
            end
        endcase
        {f_sr, f_re} = sat_fn(v_re);
        {f_si, f_im} = sat_fn(v_im);
        mag_re = NW'(n_re[EW-1] ? -n_re : n_re);
        mag_im = NW'(n_im[EW-1] ? -n_im : n_im);
        a_den  = NW'(den_s);

        a_stg.cls    = m_cls_reg;
        a_stg.fx_re  = f_re;
        a_stg.fx_im  = f_im;
        a_stg.fx_sat = f_sr || f_si;
        a_stg.den    = a_den;
        a_stg.rr_re  = XW'(mag_re) << F;
        a_stg.rr_im  = XW'(mag_im) << F;
        a_stg.q_re   = '0;
        a_stg.q_im   = '0;
        a_stg.neg_re = n_re[EW-1];
        a_stg.neg_im = n_im[EW-1];
        // quotient of 2^W or more always saturates
        a_stg.ovf_re = (CW'(mag_re) << F) >= (CW'(a_den) << W);
        a_stg.ovf_im = (CW'(mag_im) << F) >= (CW'(a_den) << W);
        // for magnitude the first sum is the squared length
        a_stg.srem   = NW'(n_re);
        a_stg.sroot  = '0;
    end

    // divide and root pipeline, one quotient and root bit per stage
    stg_t       stg_reg [W+1];
    logic [W:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[W-1:0], m_vld_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stg_reg[0] <= a_stg;
        end
    end

    for (genvar k = 0; k < W; k++) begin : g_iter
        localparam int SH = W - 1 - k;
        stg_t          nx;
        logic [CW-1:0] dsh;
        logic [RW-1:0] trial;

        always_comb begin
            nx  = stg_reg[k];
            dsh = CW'(stg_reg[k].den) << SH;
            if (CW'(stg_reg[k].rr_re) >= dsh) begin
                nx.rr_re    = XW'(CW'(stg_reg[k].rr_re) - dsh);
                nx.q_re[SH] = 1'b1;
            end
            if (CW'(stg_reg[k].rr_im) >= dsh) begin
                nx.rr_im    = XW'(CW'(stg_reg[k].rr_im) - dsh);
                nx.q_im[SH] = 1'b1;
            end
            // remainder holds s minus root squared
            trial = (RW'(stg_reg[k].sroot) << (SH + 1)) + (RW'(1) << (2 * SH));
            if (RW'(stg_reg[k].srem) >= trial) begin
                nx.srem      = NW'(RW'(stg_reg[k].srem) - trial);
                nx.sroot[SH] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                stg_reg[k+1] <= nx;
            end
        end
    end

    // final formatting
    stg_t            lst;
    logic [W-1:0]    o_re, o_im;
    logic            o_sat, o_dz, o_sr, o_si;
    logic [ST_W-1:0] o_st;

    always_comb begin
        lst   = stg_reg[W];
        o_re  = '0;
        o_im  = '0;
        o_sat = 1'b0;
        o_dz  = 1'b0;
        o_sr  = 1'b0;
        o_si  = 1'b0;
        unique case (lst.cls)
            CLS_ADD, CLS_SUB, CLS_MUL: begin
                o_re  = lst.fx_re;
                o_im  = lst.fx_im;
                o_sat = lst.fx_sat;
            end
            CLS_DIV: begin
                {o_sr, o_re} = div_fn(lst.q_re, lst.neg_re, lst.ovf_re);
                {o_si, o_im} = div_fn(lst.q_im, lst.neg_im, lst.ovf_im);
                o_sat = o_sr || o_si;
            end
            CLS_MAG: begin
                if (lst.sroot[W-1]) begin
                    o_re  = {1'b0, {(W-1){1'b1}}};
                    o_sat = 1'b1;
                end else begin
                    o_re = lst.sroot;
                end
            end
            CLS_DZ: begin
                o_dz = 1'b1;
            end
            default: begin
            end
        endcase
        o_st = o_dz ? ST_DZ : (o_sat ? ST_SAT : ST_OK);
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= vld_reg[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= {o_st, o_im, o_re};
        end
    end

endmodule

[rtl/complex_arithmetic_unit_top.sv]
// Complex ALU: add, subtract, multiply, divide and magnitude on Q16.16 operands.
// Throughput: one request per cycle while the output is not stalled, through the
// DATA_WIDTH-stage divide and root pipeline.
// A 4-entry queue between front and back end absorbs output stalls.
// Reset: synchronous, active low; empties the queue and clears all valid flags.
module complex_arithmetic_unit_top #(
    parameter int DATA_WIDTH  = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS   = cau_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = cau_pkg::QUEUE_DEPTH_DEF,
    localparam int S_TDATA_W = ((cau_pkg::OP_W + 4 * DATA_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W = ((2 * DATA_WIDTH + cau_pkg::ST_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // operation, a_re, a_im, b_re, b_im
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // result_re, result_im, status
);
    import cau_pkg::*;

    localparam int IN_W  = OP_W + 4 * DATA_WIDTH;
    localparam int ENT_W = CLS_W + 4 * DATA_WIDTH;
    localparam int OUT_W = 2 * DATA_WIDTH + ST_W;
    localparam int ST_LO = 2 * DATA_WIDTH;

    logic             push_valid, push_ready;
    logic [ENT_W-1:0] push_data;
    logic             q_valid, q_ready;
    logic [ENT_W-1:0] q_data;
    logic [OUT_W-1:0] out_data;

    // classify requests
    cau_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata[IN_W-1:0]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decoupling queue
    cau_queue #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   (push_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    // arithmetic pipeline
    cau_back #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_data   (q_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = M_TDATA_W'(out_data);

    // checks
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[ST_LO+1:ST_LO] == ST_OK || m_tdata[ST_LO+1:ST_LO] == ST_DZ ||
                      m_tdata[ST_LO+1:ST_LO] == ST_SAT))
        else $error("undefined status code on result");

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[ST_LO+1:ST_LO] == ST_DZ) |-> (m_tdata[ST_LO-1:0] == '0))
        else $error("divide by zero result not zero");

    a_full_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_valid)
        else $error("input blocked while queue empty");

endmodule
